// ----- rtl/trs_pkg.sv -----
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types and constants for the tandem repeat trim scanner.
// ----------------------------------------------------------------------------
package trs_pkg;

  // Request kinds carried on the input tuser bit
  localparam logic REQ_BASE  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam int MP_W       = 6;    // max_period register width
  localparam int PH_W       = 7;    // phase counter inside a period cell
  localparam int CNT_W      = 8;    // matched-base counter
  localparam int TOT_W      = 9;    // run length r*s before saturation
  localparam int SCAN_W     = 9;    // scan step and clipped availability
  localparam int TRIM_CELLS = 255;  // offsets a run can reach from its start

  localparam logic [CNT_W-1:0] RUN_CAP_M1 = 8'd253;  // stop counting at 254
  localparam logic [7:0]       TRIM_CAP   = 8'd255;
  localparam logic [MP_W-1:0]  MP_RESET   = 6'd18;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REDUCE,
    ST_EMIT
  } state_t;

  // Broadcast from the sequencer to every period cell
  typedef struct packed {
    logic            start;
    logic            feed;
    logic            avail;
    logic [7:0]      data;
    logic [MP_W-1:0] max_period;
  } scan_bus_t;

  // Base byte handed from one period cell to the next
  typedef struct packed {
    logic       fed;
    logic [7:0] data;
  } link_t;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
  } trim_t;

endpackage

// ----- rtl/trs_ram.sv -----
// ----------------------------------------------------------------------------
// trs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module trs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/trs_period_cell.sv -----
// ----------------------------------------------------------------------------
// trs_period_cell
// One repeat period S. Holds the base fed S steps ago, counts the matching
// bases from the scan start and tracks the run length in whole copies.
// ----------------------------------------------------------------------------
module trs_period_cell #(
  parameter int S = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  trs_pkg::scan_bus_t bus,
  input  trs_pkg::link_t    link_in,
  output trs_pkg::link_t    link_out,
  input  logic [7:0]        carry_in,
  output logic [7:0]        carry_out,
  output logic              busy
);

  localparam logic [trs_pkg::PH_W-1:0]  PH_LAST = trs_pkg::PH_W'(S - 1);
  localparam logic [trs_pkg::PH_W-1:0]  PERIOD  = trs_pkg::PH_W'(S);
  localparam logic [trs_pkg::TOT_W-1:0] STEP    = trs_pkg::TOT_W'(S);

  trs_pkg::link_t              link_q;
  logic                        active;
  logic [trs_pkg::CNT_W-1:0]   cnt;
  logic [trs_pkg::PH_W-1:0]    ph;
  logic [trs_pkg::TOT_W-1:0]   tot;
  logic                        rep;
  logic [7:0]                  carry;
  logic                        step;
  logic                        match;
  logic [7:0]                  cand;

  assign step  = active && bus.feed && link_q.fed;
  assign match = bus.avail && (bus.data == link_q.data);

  // Candidate run length, 1 when no second copy was seen
  always_comb begin
    if (!rep) begin
      cand = 8'd1;
    end else if (tot > trs_pkg::TOT_W'(trs_pkg::TRIM_CAP)) begin
      cand = trs_pkg::TRIM_CAP;
    end else begin
      cand = tot[7:0];
    end
  end

  // Control state and neighbor data
  always_ff @(posedge clk) begin
    link_q.data <= link_in.data;
    if (rst) begin
      active     <= 1'b0;
      link_q.fed <= 1'b0;
    end else if (bus.start) begin
      active     <= ({1'b0, bus.max_period} >= PERIOD);
      link_q.fed <= 1'b0;
    end else begin
      link_q.fed <= link_in.fed;
      if (step && (!match || cnt == trs_pkg::RUN_CAP_M1)) begin
        active <= 1'b0;
      end
    end
  end

  // Run counters
  always_ff @(posedge clk) begin
    carry <= (cand > carry_in) ? cand : carry_in;
    if (bus.start) begin
      cnt <= '0;
      ph  <= '0;
      tot <= STEP;
      rep <= 1'b0;
    end else if (step && match) begin
      cnt <= cnt + 1'b1;
      if (ph == PH_LAST) begin
        ph  <= '0;
        tot <= tot + STEP;
        rep <= 1'b1;
      end else begin
        ph <= ph + 1'b1;
      end
    end
  end

  assign link_out  = link_q;
  assign carry_out = carry;
  assign busy      = active;

endmodule

// ----- rtl/trs_trim_cell.sv -----
// ----------------------------------------------------------------------------
// trs_trim_cell
// Trim pair of one pending position. On each emit it takes its neighbor's
// pair and applies the run found at the emitted position, at offset OFF.
// ----------------------------------------------------------------------------
module trs_trim_cell #(
  parameter int OFF = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  logic [7:0]                 best,
  input  logic [trs_pkg::SCAN_W-1:0] avail,
  input  trs_pkg::trim_t             nbr,
  output trs_pkg::trim_t             q
);

  localparam logic [trs_pkg::SCAN_W-1:0] OFF_W = trs_pkg::SCAN_W'(OFF);
  localparam logic [7:0]                 OFF_B = 8'(OFF);
  localparam logic [7:0]                 OFF_R = 8'(OFF + 1);  // right trim at this offset

  logic           hit;
  logic [7:0]     lval;
  trs_pkg::trim_t spread;

  // Offset lies inside the run and inside the received bases
  assign hit  = ({1'b0, best} > OFF_W) && (avail > OFF_W);
  assign lval = best - OFF_B;

  always_comb begin
    spread = nbr;
    if (hit) begin
      if (nbr.right < OFF_R) spread.right = OFF_R;
      if (nbr.left < lval)   spread.left  = lval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= spread;
    end
  end

endmodule

// ----- rtl/tandem_repeat_trim_scan.sv -----
// ----------------------------------------------------------------------------
// tandem_repeat_trim_scan
// Per-position tandem repeat scanner giving left and right trims.
// ----------------------------------------------------------------------------
// A base or drain word that produces no result is accepted without a scan. A word
// that releases a position scans it: the window RAM streams bases from that
// position through a chain of MAX_PERIOD_LIMIT period cells, one base a cycle,
// until every enabled cell has hit a mismatch, the end of the received bases,
// or a run of 254 matches; the scan length is set by the longest repeat run
// there. A max reduction over the cell chain follows, then the result register
// is loaded, held off while a previous result word is still stalled. Trims of
// pending positions sit in a chain of 255 cells updated in parallel. The
// window RAM has no clearing pass after reset.
// ----------------------------------------------------------------------------
module tandem_repeat_trim_scan #(
  parameter int MAX_PERIOD_LIMIT = 32,
  parameter int WINDOW_DEPTH     = 512
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // base
  input  logic        s_tuser,   // req_type
  input  logic        s_tlast,   // last_base
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // position[31:0], left[39:32], right[47:40]
  output logic        m_tlast,   // final_position
  // max_period register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int RW = $clog2(MAX_PERIOD_LIMIT + 2);
  localparam logic [31:0]    LOOKAHEAD = 32'(253 + MAX_PERIOD_LIMIT);
  localparam logic [AW-1:0]  PTR_LAST  = AW'(WINDOW_DEPTH - 1);
  localparam logic [RW-1:0]  RED_LAST  = RW'(MAX_PERIOD_LIMIT);

  trs_pkg::state_t state, state_next;

  logic [31:0]                 br, pe;
  logic                        ended;
  logic [trs_pkg::SCAN_W-1:0]  avail_c;
  logic [trs_pkg::SCAN_W-1:0]  scan_t;
  logic [AW-1:0]               wr_ptr, rd_ptr, scan_ptr;
  logic                        feed_q, avail_q;
  logic [RW-1:0]               red_cnt;
  logic [trs_pkg::MP_W-1:0]    max_period;
  logic [7:0]                  rdata;
  logic [MAX_PERIOD_LIMIT-1:0] busy;

  logic        in_fire, restart, do_write, emit_dec, out_free, emit_go, scan_on;
  logic [31:0] br0, pe0, br1, pend;
  logic        end0, end1;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_period <= trs_pkg::MP_RESET;
    end else if (cfg_valid) begin
      max_period <= cfg_data;
    end
  end

  // Input word bookkeeping
  assign in_fire  = s_tvalid && s_tready;
  assign restart  = (s_tuser == trs_pkg::REQ_BASE) && ended && (br == pe);
  assign br0      = restart ? '0 : br;
  assign pe0      = restart ? '0 : pe;
  assign end0     = restart ? 1'b0 : ended;
  assign do_write = in_fire && (s_tuser == trs_pkg::REQ_BASE) && !end0;
  assign br1      = do_write ? br0 + 32'd1 : br0;
  assign end1     = end0 || (do_write && s_tlast);
  assign pend     = br1 - pe0;
  assign emit_dec = end1 ? (pend != '0) : (pend > LOOKAHEAD);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      trs_pkg::ST_IDLE:   if (in_fire && emit_dec) state_next = trs_pkg::ST_SCAN;
      trs_pkg::ST_SCAN:   if (!(|busy)) state_next = trs_pkg::ST_REDUCE;
      trs_pkg::ST_REDUCE: if (red_cnt == RED_LAST) state_next = trs_pkg::ST_EMIT;
      trs_pkg::ST_EMIT:   if (out_free) state_next = trs_pkg::ST_IDLE;
      default:            state_next = trs_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  assign out_free = !m_tvalid || m_tready;
  always_comb begin
    s_tready = 1'b0;
    scan_on  = 1'b0;
    emit_go  = 1'b0;
    unique case (state)
      trs_pkg::ST_IDLE:   s_tready = 1'b1;
      trs_pkg::ST_SCAN:   scan_on  = 1'b1;
      trs_pkg::ST_REDUCE: ;
      trs_pkg::ST_EMIT:   emit_go  = out_free;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= trs_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Counters and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      br      <= '0;
      pe      <= '0;
      ended   <= 1'b0;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      feed_q  <= 1'b0;
      red_cnt <= '0;
    end else begin
      feed_q <= scan_on;
      if (in_fire) begin
        br    <= br1;
        pe    <= pe0;
        ended <= end1;
      end else if (emit_go) begin
        pe <= pe + 32'd1;
      end
      if (do_write) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (emit_go)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (state == trs_pkg::ST_REDUCE) red_cnt <= red_cnt + 1'b1;
      else                             red_cnt <= '0;
    end
  end

  // Scan address and availability
  always_ff @(posedge clk) begin
    avail_q <= scan_t < avail_c;
    if (in_fire) begin
      avail_c  <= (pend[31:trs_pkg::SCAN_W] != '0) ? '1 : pend[trs_pkg::SCAN_W-1:0];
      scan_t   <= '0;
      scan_ptr <= rd_ptr;
    end else if (scan_on) begin
      scan_t   <= scan_t + 1'b1;
      scan_ptr <= (scan_ptr == PTR_LAST) ? '0 : scan_ptr + 1'b1;
    end
  end

  trs_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_window (
    .clk   (clk),
    .we    (do_write),
    .waddr (wr_ptr),
    .wdata (s_tdata),
    .raddr (scan_ptr),
    .rdata (rdata)
  );

  // Period cell chain
  trs_pkg::scan_bus_t bus;
  trs_pkg::link_t     link  [MAX_PERIOD_LIMIT+1];
  logic [7:0]         carry [1:MAX_PERIOD_LIMIT+1];

  assign bus.start      = in_fire && emit_dec;
  assign bus.feed       = feed_q;
  assign bus.avail      = avail_q;
  assign bus.data       = rdata;
  assign bus.max_period = max_period;
  assign link[0].fed    = feed_q;
  assign link[0].data   = rdata;
  assign carry[MAX_PERIOD_LIMIT+1] = 8'd1;

  for (genvar s = 1; s <= MAX_PERIOD_LIMIT; s++) begin : g_period
    trs_period_cell #(.S(s)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .bus       (bus),
      .link_in   (link[s-1]),
      .link_out  (link[s]),
      .carry_in  (carry[s+1]),
      .carry_out (carry[s]),
      .busy      (busy[s-1])
    );
  end

  // Trim cell chain, cell o holds position pe + o
  trs_pkg::trim_t trim [trs_pkg::TRIM_CELLS];
  trs_pkg::trim_t nbr  [trs_pkg::TRIM_CELLS];
  logic [7:0]     best;

  assign best = carry[1];

  for (genvar o = 0; o < trs_pkg::TRIM_CELLS; o++) begin : g_trim
    if (o == trs_pkg::TRIM_CELLS - 1) begin : g_end
      assign nbr[o] = '0;
    end else begin : g_mid
      assign nbr[o] = trim[o+1];
    end
    trs_trim_cell #(.OFF(o + 1)) u_trim (
      .clk   (clk),
      .rst   (rst),
      .shift (emit_go),
      .best  (best),
      .avail (avail_c),
      .nbr   (nbr[o]),
      .q     (trim[o])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_tdata[31:0]  <= pe;
      m_tdata[39:32] <= (trim[0].left > best) ? trim[0].left : best;
      m_tdata[47:40] <= (trim[0].right != '0) ? trim[0].right : 8'd1;
      m_tlast        <= ended && (avail_c == trs_pkg::SCAN_W'(1));
    end
  end

endmodule

// ----- rtl/trs_check.sv -----
// ----------------------------------------------------------------------------
// trs_check
// Port-level checks for the tandem repeat trim scanner, bound to the top.
// ----------------------------------------------------------------------------
module trs_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tuser,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [5:0]  cfg_data
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // every position lies in its own run
  a_left: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:32] != 8'd0)
    else $error("left trim is zero");

  a_right: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[47:40] != 8'd0)
    else $error("right trim is zero");

  // nothing precedes position zero
  a_first: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[31:0] == 32'd0 |-> m_tdata[47:40] == 8'd1)
    else $error("first position has right trim above one");

endmodule

bind tandem_repeat_trim_scan trs_check u_trs_check (.*);

// ----- tb/sv/tb_tandem_repeat_trim_scan.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tandem_repeat_trim_scan
// Self-checking bench for the tandem repeat trim scanner.
// ----------------------------------------------------------------------------
// Sequences built from tandem repeats, random runs and homopolymers are fed
// word by word, then flushed with drain words. A behavioral scanner in the
// bench tracks the window, the trim stores and the counters, and predicts
// each result word. The max_period register is rewritten between sequences
// while the block is idle. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb_tandem_repeat_trim_scan;

  localparam int          PERIOD_LIMIT = 32;
  localparam int          DEPTH        = 512;
  localparam logic [31:0] LOOKAHEAD    = 32'd285;  // 253 + period limit
  localparam int          CAP          = 255;
  localparam int          SETTLE       = 400;      // cycles past the last result
  localparam int          WORD_TARGET  = 1650;
  localparam int          LONG_WORDS   = 900;      // most words a long sequence adds

  typedef enum logic [1:0] {K_WORD, K_CFG, K_HOLD} job_kind_t;

  typedef struct {
    job_kind_t  kind;
    logic       req;
    logic [7:0] data;
    logic       last;
    logic [5:0] cfg;
  } job_t;

  typedef struct {
    logic [31:0] pos;
    logic [7:0]  left;
    logic [7:0]  right;
    logic        fin;
  } trim_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;

  tandem_repeat_trim_scan #(
    .MAX_PERIOD_LIMIT(PERIOD_LIMIT),
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Scanner state mirrored in the bench
  logic [7:0]  win_mem [DEPTH];
  logic [7:0]  lt_mem  [DEPTH];
  logic [7:0]  rt_mem  [DEPTH];
  logic [31:0] n_rcv = '0;
  logic [31:0] n_out = '0;
  logic        ended = 1'b0;
  logic [5:0]  mp_reg = trs_pkg::MP_RESET;

  job_t        job_q[$];
  trim_res_t   trim_q[$];
  int          word_cnt = 0;
  int          err_cnt = 0;
  int          idle_cycles = 0;
  bit          s_acc = 0;
  bit          cfg_acc = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rx_tick = 0;
  int          rx_mode = 0;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      lt_mem[i] = '0;
      rt_mem[i] = '0;
      win_mem[i] = '0;
    end
  end

  // Does copy r of period s at position q match copy 0?
  function automatic bit copy_ok(logic [31:0] q, int s, int r, logic [31:0] avail);
    int off;
    off = r * s;
    for (int i = 0; i < s; i++) begin
      if (i + off >= avail) return 0;
      if (win_mem[(q + i) % DEPTH] != win_mem[(q + i + off) % DEPTH]) return 0;
    end
    return 1;
  endfunction

  // One input word through the scanner; returns 1 when a position is released
  function automatic bit scan_word(logic req, logic [7:0] b, logic last,
                                   output trim_res_t res);
    logic [31:0] pend;
    logic [31:0] q;
    logic [31:0] avail;
    int          periods;
    int          best;
    int          r;
    int          k;
    res = '{default: '0};
    if (req == trs_pkg::REQ_BASE && ended && n_rcv == n_out) begin
      n_rcv = '0;
      n_out = '0;
      ended = 1'b0;
    end
    if (req == trs_pkg::REQ_BASE && !ended) begin
      win_mem[n_rcv % DEPTH] = b;
      n_rcv = n_rcv + 1;
      if (last) ended = 1'b1;
    end
    pend = n_rcv - n_out;
    if (!(ended ? (pend > 0) : (pend > LOOKAHEAD))) return 0;

    q = n_out;
    avail = n_rcv - q;
    periods = (mp_reg < PERIOD_LIMIT) ? mp_reg : PERIOD_LIMIT;
    best = 1;
    for (int s = 1; s <= periods; s++) begin
      r = 1;
      while (r * s < CAP && copy_ok(q, s, r, avail)) r++;
      if (r > 1 && r * s > best) best = r * s;
    end
    if (best > CAP) best = CAP;
    // spread the run over the positions it covers
    for (int o = 0; o < best && o < avail; o++) begin
      k = (q + o) % DEPTH;
      if (o + 1 > rt_mem[k]) rt_mem[k] = 8'(o + 1);
      if (best - o > lt_mem[k]) lt_mem[k] = 8'(best - o);
    end
    k = q % DEPTH;
    res.pos = q;
    res.left = lt_mem[k];
    res.right = rt_mem[k];
    res.fin = ended && avail == 1;
    lt_mem[k] = '0;
    rt_mem[k] = '0;
    n_out = q + 1;
    return 1;
  endfunction

  // Predict on accepted words, check result words
  always @(posedge clk) begin : mon
    trim_res_t res;
    trim_res_t exp_res;
    s_acc = s_tvalid && s_tready;
    cfg_acc = cfg_valid && cfg_ready;
    if (!rst) begin
      if (cfg_acc) mp_reg = cfg_data;
      if (s_acc && scan_word(s_tuser, s_tdata, s_tlast, res)) trim_q.push_back(res);
      if (m_tvalid && m_tready) begin
        if (trim_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result word pos=%0d left=%0d right=%0d fin=%0b",
                     m_tdata[31:0], m_tdata[39:32], m_tdata[47:40], m_tlast);
        end else begin
          exp_res = trim_q.pop_front();
          if (m_tdata[31:0] !== exp_res.pos || m_tdata[39:32] !== exp_res.left ||
              m_tdata[47:40] !== exp_res.right || m_tlast !== exp_res.fin) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"mismatch: exp pos=%0d left=%0d right=%0d fin=%0b, ",
                        "got pos=%0d left=%0d right=%0d fin=%0b"},
                       exp_res.pos, exp_res.left, exp_res.right, exp_res.fin,
                       m_tdata[31:0], m_tdata[39:32], m_tdata[47:40], m_tlast);
          end
        end
      end
      if (trim_q.size() == 0 && !s_tvalid && !s_acc) idle_cycles++;
      else idle_cycles = 0;
    end
  end

  // Word driver: bursts with random gaps, config writes only when idle
  always @(negedge clk) begin : drv
    logic       nv;
    logic [7:0] nd;
    logic       nu;
    logic       nl;
    logic       ncv;
    logic [5:0] ncd;
    nv = s_tvalid; nd = s_tdata; nu = s_tuser; nl = s_tlast;
    ncv = cfg_valid; ncd = cfg_data;
    if (!rst) begin
      if (s_tvalid && s_acc) nv = 1'b0;
      if (cfg_valid && cfg_acc) ncv = 1'b0;
      if (!nv && !ncv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (job_q.size() > 0) begin
          case (job_q[0].kind)
            K_WORD: begin
              nv = 1'b1; nd = job_q[0].data; nu = job_q[0].req; nl = job_q[0].last;
              void'(job_q.pop_front());
              if (burst_left > 0) begin
                burst_left--;
              end else begin
                burst_left = $urandom_range(0, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
              end
            end
            K_CFG: begin
              if (idle_cycles >= SETTLE) begin
                ncv = 1'b1; ncd = job_q[0].cfg;
                void'(job_q.pop_front());
              end
            end
            K_HOLD: begin
              if (trim_q.size() == 0) void'(job_q.pop_front());
            end
            default: ;
          endcase
        end
      end
    end
    s_tvalid <= nv; s_tdata <= nd; s_tuser <= nu; s_tlast <= nl;
    cfg_valid <= ncv; cfg_data <= ncd;
  end

  // Result receiver: switches among always ready, random and heavy stall
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 300 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic add_word(logic req, logic [7:0] b, logic last);
    job_t j;
    j = '{kind: K_WORD, req: req, data: b, last: last, cfg: '0};
    job_q.push_back(j);
    word_cnt++;
  endtask

  task automatic add_cfg(logic [5:0] v);
    job_t j;
    j = '{kind: K_CFG, req: trs_pkg::REQ_BASE, data: '0, last: 1'b0, cfg: v};
    job_q.push_back(j);
  endtask

  task automatic add_hold();
    job_t j;
    j = '{kind: K_HOLD, req: trs_pkg::REQ_BASE, data: '0, last: 1'b0, cfg: '0};
    job_q.push_back(j);
  endtask

  // Feed one sequence, then flush it; some drains become ignored bases
  task automatic send_seq(logic [7:0] seq[$], bit noisy);
    int n;
    int d;
    n = seq.size();
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 19) == 0)
        add_word(trs_pkg::REQ_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      add_word(trs_pkg::REQ_BASE, seq[i], i == n - 1);
    end
    d = (n - 1 < LOOKAHEAD) ? n - 1 : LOOKAHEAD;
    for (int i = 0; i < d; i++) begin
      if (i < d - 1 && $urandom_range(0, 9) == 0)
        add_word(trs_pkg::REQ_BASE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else
        add_word(trs_pkg::REQ_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    if (noisy) begin
      repeat ($urandom_range(0, 2))
        add_word(trs_pkg::REQ_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Random sequence of repeats and random stretches over a small alphabet or all bytes
  task automatic gen_seq(int len);
    logic [7:0] seq[$];
    logic [7:0] sym[8];
    logic [7:0] unit[$];
    int         alph;
    int         p;
    int         copies;
    alph = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 8);
    for (int i = 0; i < 8; i++) sym[i] = 8'($urandom_range(0, 255));
    while (seq.size() < len) begin
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 10))
          seq.push_back(alph == 0 ? 8'($urandom_range(0, 255))
                                  : sym[$urandom_range(0, alph - 1)]);
      end else begin
        p = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(1, 40);
        unit.delete();
        repeat (p)
          unit.push_back(alph == 0 ? 8'($urandom_range(0, 255))
                                   : sym[$urandom_range(0, alph - 1)]);
        copies = $urandom_range(2, (len > 100) ? 300 / p + 2 : 40 / p + 2);
        repeat (copies) foreach (unit[i]) seq.push_back(unit[i]);
      end
    end
    while (seq.size() > len) void'(seq.pop_back());
    send_seq(seq, 1);
  endtask

  // Stimulus and end of run
  initial begin : stim
    logic [5:0] cfg_pick[7];
    int         nseq;
    // directed: empty drain, alternating extremes, single base, homopolymer, period-3 repeat
    add_word(trs_pkg::REQ_DRAIN, 8'hFF, 1'b1);
    send_seq('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h41}, 1'b0);
    add_word(trs_pkg::REQ_DRAIN, 8'h00, 1'b0);
    send_seq('{8'h5A}, 1'b0);
    add_hold();
    add_cfg(6'd0);
    send_seq('{8'h41, 8'h41, 8'h41, 8'h41}, 1'b0);
    add_cfg(6'd63);
    send_seq('{8'h41, 8'h43, 8'h47, 8'h41, 8'h43, 8'h47, 8'h41, 8'h43}, 1'b0);

    // random part
    cfg_pick = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd18, 6'd2, 6'd33};
    nseq = 0;
    while (word_cnt < WORD_TARGET) begin
      if (nseq % 6 == 0) begin
        add_hold();
        add_cfg(($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                             : cfg_pick[$urandom_range(0, 6)]);
      end else if ($urandom_range(0, 4) == 0) begin
        add_hold();
      end
      if (word_cnt < WORD_TARGET - LONG_WORDS && $urandom_range(0, 12) == 0)
        gen_seq($urandom_range(260, 600));
      else gen_seq($urandom_range(1, 40));
      nseq++;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (job_q.size() == 0 && !s_tvalid && !cfg_valid && trim_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0 && trim_q.size() == 0) begin
      $display("tb_tandem_repeat_trim_scan OK");
    end else begin
      $display("tb_tandem_repeat_trim_scan NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("tb_tandem_repeat_trim_scan NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/trs_pkg.sv
rtl/trs_ram.sv
rtl/trs_period_cell.sv
rtl/trs_trim_cell.sv
rtl/tandem_repeat_trim_scan.sv
rtl/trs_check.sv
tb/sv/tb_tandem_repeat_trim_scan.sv
